FILE: rtl/core/mie_pkg.sv
package mie_pkg;

    localparam int VALUE_WIDTH_DEF = 31;
    localparam int VALUE_WIDTH_MIN = 8;
    localparam int VALUE_WIDTH_MAX = 63;

endpackage

FILE: rtl/core/mie_if.sv
interface mie_in_if #(
    parameter int W = mie_pkg::VALUE_WIDTH_DEF
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

interface mie_out_if #(
    parameter int W = mie_pkg::VALUE_WIDTH_DEF
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] inverse;
    logic         no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

FILE: rtl/core/mie_div.sv
// Shift-subtract divider. Divisor is aligned upward first, then one quotient
// bit per cycle; each quotient bit also folds i_coef into o_prod (Horner form),
// so o_prod ends as quotient * i_coef.
module mie_div #(
    parameter int W = mie_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    input  logic signed [W:0]   i_coef,
    output logic                o_done,
    output logic [W-1:0]        o_rem,
    output logic signed [W:0]   o_prod
);
    import mie_pkg::*;

    localparam int CW = $clog2(W);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_ALIGN = 2'd1;
    localparam logic [1:0] P_SUB   = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic              r_done, n_done;
    logic [W-1:0]      r_rem, n_rem;
    logic [W-1:0]      r_d, n_d;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic signed [W:0] r_prod, n_prod;
    logic              ge;

    assign ge = (r_rem >= r_d);

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_d     = r_d;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_rem   = i_dividend;
                    n_d     = i_divisor;
                    n_cnt   = '0;
                    n_prod  = '0;
                    n_phase = P_ALIGN;
                end
            end
            P_ALIGN: begin
                // 2d <= rem  <=>  d <= rem/2 (floor), so d never overflows W bits
                if (r_d <= (r_rem >> 1)) begin
                    n_d   = r_d << 1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_phase = P_SUB;
                end
            end
            P_SUB: begin
                if (ge) begin
                    n_rem = r_rem - r_d;
                end
                n_prod = (r_prod <<< 1) + (ge ? i_coef : '0);
                if (r_cnt == '0) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_d   = r_d >> 1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_rem  <= n_rem;
        r_d    <= n_d;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

FILE: rtl/core/modular_inverse_ext_euclid_top.sv
// Modular inverse by extended Euclid over one shared shift-subtract divider.
// Each transaction first reduces the operand modulo the modulus, then runs one
// division per Euclid step until the new remainder is zero, then finishes.
// Throughput: one transaction at a time; the next operand is taken once the
// result is handed to the output register, which may still be waiting.
// Reset (synchronous, active low) returns to idle, drops o_out.valid, modulus = 1.
module modular_inverse_ext_euclid_top #(
    parameter int VALUE_WIDTH = mie_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [VALUE_WIDTH-1:0] i_cfg_wr_data,
    mie_in_if.sink                 i_in,
    mie_out_if.source              o_out
);
    import mie_pkg::*;

    localparam int W = VALUE_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_EUC   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [W-1:0]      r_mod;
    logic [W-1:0]      r_r, n_r;
    logic [W-1:0]      r_nr, n_nr;
    logic signed [W:0] r_t, n_t;
    logic signed [W:0] r_nt, n_nt;
    logic              r_ov, n_ov;
    logic [W-1:0]      r_inv, n_inv;
    logic              r_none, n_none;

    logic              in_acc;
    logic              div_start;
    logic [W-1:0]      div_dividend;
    logic [W-1:0]      div_divisor;
    logic              div_done;
    logic [W-1:0]      div_rem;
    logic signed [W:0] div_prod;
    logic [W:0]        t_lift;
    logic              out_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ov || o_out.ready;

    assign div_start    = (in_acc && (r_mod != '0)) || ((r_state == S_CHECK) && (r_nr != '0));
    assign div_dividend = (r_state == S_IDLE) ? i_in.operand : r_r;
    assign div_divisor  = (r_state == S_IDLE) ? r_mod : r_nr;

    // negative coefficient is lifted into 0..modulus-1
    assign t_lift = r_t + {1'b0, r_mod};

    mie_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_coef     (r_nt),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod     (div_prod)
    );

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_nr    = r_nr;
        n_t     = r_t;
        n_nt    = r_nt;
        n_ov    = r_ov && !o_out.ready;
        n_inv   = r_inv;
        n_none  = r_none;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_mod == '0) begin
                        n_r     = '0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (div_done) begin
                    n_r     = r_mod;
                    n_nr    = div_rem;
                    n_t     = '0;
                    n_nt    = (W+1)'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_nr == '0) ? S_FIN : S_EUC;
            end
            S_EUC: begin
                if (div_done) begin
                    n_t     = r_nt;
                    n_nt    = r_t - div_prod;
                    n_r     = r_nr;
                    n_nr    = div_rem;
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_none  = (r_r != W'(1));
                    n_inv   = (r_r != W'(1)) ? '0 :
                              (r_t[W] ? t_lift[W-1:0] : r_t[W-1:0]);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_mod   <= W'(1);
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            if (i_cfg_wr_en) begin
                r_mod <= i_cfg_wr_data;
            end
        end
        r_r    <= n_r;
        r_nr   <= n_nr;
        r_t    <= n_t;
        r_nt   <= n_nt;
        r_inv  <= n_inv;
        r_none <= n_none;
    end

    assign o_out.valid      = r_ov;
    assign o_out.inverse    = r_inv;
    assign o_out.no_inverse = r_none;

endmodule

FILE: rtl/core/mie_chk.sv
module mie_chk #(
    parameter int W = mie_pkg::VALUE_WIDTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_out_inverse,
    input logic         i_out_no_inverse
);
    import mie_pkg::*;

    // stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_inverse) && $stable(i_out_no_inverse))
        else $error("result changed while stalled");

    // a no-inverse result carries a zero inverse
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_no_inverse |-> (i_out_inverse == '0))
        else $error("no_inverse with nonzero inverse");

    // an accepted operand makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready after accept");

    // ready drops only because an operand was taken
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid))
        else $error("ready dropped without a transaction");

endmodule

bind modular_inverse_ext_euclid_top mie_chk #(.W(VALUE_WIDTH)) u_mie_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_inverse    (o_out.inverse),
    .i_out_no_inverse (o_out.no_inverse)
);
